FILE: hdl/bad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_pkg: shared types and constants of the box average downscaler
// Register indexes, state codes and the controller/datapath command/status structs.
// ----------------------------------------------------------------------------
package bad_pkg;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 13;
   localparam int PIXEL_WIDTH     = 8;
   localparam int SUM_WIDTH       = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_SRC_WIDTH    = 3'd0,
      REG_SRC_HEIGHT   = 3'd1,
      REG_DST_WIDTH    = 3'd2,
      REG_DST_HEIGHT   = 3'd3,
      REG_BLOCK_FACTOR = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic load;
      logic update;
      logic div_start;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic pass;
      logic emit;
      logic div_done;
      logic rsp_full;
   } status_type;
endpackage

FILE: hdl/bad_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_stream_if: valid/ready channel
// Generic handshake interface carrying a packed payload.
// ----------------------------------------------------------------------------
interface bad_stream_if #(parameter int WIDTH = 24) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/bad_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_ram: single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module bad_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data <= mem_ff[addr];
   end
endmodule

FILE: hdl/bad_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_ctrl: sequencing state machine
// Steps one accepted word through read and, as it needs them, write and divide phases.
// ----------------------------------------------------------------------------
module bad_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  bad_pkg::status_type status,
   output bad_pkg::cmd_type    cmd,
   output logic                req_ready
);
   import bad_pkg::*;
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !status.rsp_full;
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // wait for the registered row store read
            state_in = status.pass ? ST_WRITE : ST_IDLE;
         end
         ST_WRITE: begin
            cmd.update = 1'b1;
            if (status.emit) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

FILE: hdl/bad_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bad_datapath: counters, crop test, row store and divider
// Tracks the raster position, accumulates column sums, divides by area.
// ----------------------------------------------------------------------------
module bad_datapath #(
   parameter int MAX_SOURCE_SIDE = 4096,
   parameter int MAX_DEST_WIDTH  = 1024,
   parameter int MAX_FACTOR      = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [12:0]         src_width,
   input  logic [12:0]         src_height,
   input  logic [10:0]         dst_width,
   input  logic [12:0]         dst_height,
   input  logic [4:0]          block_factor,
   input  logic [23:0]         pixel,
   input  bad_pkg::cmd_type    cmd,
   output bad_pkg::status_type status,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [25:0]         rsp_data
);
   import bad_pkg::*;
   localparam int PW = $clog2(MAX_SOURCE_SIDE + 1);
   localparam int AW = $clog2(MAX_DEST_WIDTH);
   localparam int FW = $clog2(MAX_FACTOR);
   localparam int AREA_W = 2 * FW + 1;

   logic [PW-1:0] col_ff, row_ff, col_in, row_in;
   logic [FW-1:0] sc_ff, sr_ff;
   logic [AW:0]   dc_ff;
   logic [13:0]   dr_ff;
   logic          err_ff;
   logic [23:0]   pix_ff;
   logic          pass_ff, first_ff, last_ff, emit_ff, frame_last_ff;

   // geometry
   logic [23:0] span_c, span_r;
   logic [23:0] off_c, off_r;
   logic        valid_cfg;
   logic [12:0] cw, ch;
   assign span_c = 24'(dst_width) * 24'(block_factor);
   assign span_r = 24'(dst_height) * 24'(block_factor);
   assign valid_cfg = src_width != 0 && 32'(src_width) <= MAX_SOURCE_SIDE
      && src_height != 0 && 32'(src_height) <= MAX_SOURCE_SIDE
      && dst_width != 0 && 32'(dst_width) <= MAX_DEST_WIDTH && dst_height != 0
      && block_factor != 0 && 32'(block_factor) <= MAX_FACTOR
      && span_c <= 24'(src_width) && span_r <= 24'(src_height);
   assign off_c = (24'(src_width) - span_c) >> 1;
   assign off_r = (24'(src_height) - span_r) >> 1;
   assign cw = (src_width == 0) ? 13'd1 :
      (32'(src_width) > MAX_SOURCE_SIDE) ? 13'(MAX_SOURCE_SIDE) : src_width;
   assign ch = (src_height == 0) ? 13'd1 :
      (32'(src_height) > MAX_SOURCE_SIDE) ? 13'(MAX_SOURCE_SIDE) : src_height;

   logic start, err_now, in_c, in_r;
   logic [FW-1:0] fm1;
   assign start = col_ff == 0 && row_ff == 0;
   assign err_now = start ? !valid_cfg : err_ff;
   assign in_c = 24'(col_ff) >= off_c && 24'(col_ff) < off_c + span_c;
   assign in_r = 24'(row_ff) >= off_r && 24'(row_ff) < off_r + span_r;
   assign fm1 = FW'(block_factor - 5'd1);

   // raster counters advance on every accepted word, wrapping at the source width and height
   always_comb begin
      col_in = col_ff + 1'b1;
      row_in = row_ff;
      if (13'(col_ff) + 13'd1 >= cw) begin
         col_in = '0;
         row_in = (13'(row_ff) + 13'd1 >= ch) ? '0 : row_ff + 1'b1;
      end
   end

   logic [SUM_WIDTH*3-1:0] rd_data, wr_data;
   logic [AW-1:0] addr;
   assign addr = dc_ff[AW-1:0];

   logic err_word, norm_word;
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0; err_ff <= 1'b0;
         sc_ff <= '0; sr_ff <= '0; dc_ff <= '0; dr_ff <= '0;
         pass_ff <= 1'b0;
      end else if (cmd.load) begin
         col_ff <= col_in; row_ff <= row_in;
         err_ff <= err_now;
         pix_ff <= pixel;
         pass_ff <= !err_now && valid_cfg && in_c && in_r;
         first_ff <= sc_ff == 0 && sr_ff == 0;
         last_ff  <= sc_ff == fm1 && sr_ff == fm1;
         frame_last_ff <= 32'(dc_ff) == 32'(dst_width) - 1
            && 32'(dr_ff) == 32'(dst_height) - 1;
         if (!err_now && valid_cfg && in_c && in_r) begin
            // step block coordinates
            if (sc_ff == fm1) begin
               sc_ff <= '0;
               if (32'(dc_ff) + 1 >= 32'(dst_width)) begin
                  dc_ff <= '0;
                  if (sr_ff == fm1) begin
                     sr_ff <= '0;
                     dr_ff <= (32'(dr_ff) + 1 >= 32'(dst_height)) ? '0 : dr_ff + 1'b1;
                  end else sr_ff <= sr_ff + 1'b1;
               end else dc_ff <= dc_ff + 1'b1;
            end else sc_ff <= sc_ff + 1'b1;
         end
         if (start) begin
            // new frame: rewind block coordinates to the crop origin
            sc_ff <= '0; sr_ff <= '0; dc_ff <= '0; dr_ff <= '0;
            if (!(!valid_cfg) && in_c && in_r) sc_ff <= (fm1 == 0) ? '0 : FW'(1);
            if (valid_cfg && in_c && in_r && fm1 == 0)
               dc_ff <= (dst_width == 1) ? '0 : (AW+1)'(1);
            if (valid_cfg && in_c && in_r && fm1 == 0 && dst_width == 1)
               dr_ff <= (dst_height == 1) ? '0 : 14'd1;
         end
      end
   end
   assign err_word  = cmd.load && start && !valid_cfg;
   assign norm_word = 1'b0;

   // address for the row store is the column being written, latched at load
   logic [AW-1:0] waddr_ff;
   always_ff @(posedge clock) if (cmd.load) waddr_ff <= addr;

   logic [SUM_WIDTH-1:0] sr_s, sg_s, sb_s;
   assign sr_s = (first_ff ? '0 : rd_data[47:32]) + 16'(pix_ff[23:16]);
   assign sg_s = (first_ff ? '0 : rd_data[31:16]) + 16'(pix_ff[15:8]);
   assign sb_s = (first_ff ? '0 : rd_data[15:0])  + 16'(pix_ff[7:0]);
   assign wr_data = {sr_s, sg_s, sb_s};

   // hold the latched column until the write so the read data stays put
   bad_ram #(.WIDTH(3 * SUM_WIDTH), .DEPTH(MAX_DEST_WIDTH)) u_ram (
      .clock(clock), .wr_en(cmd.update && pass_ff),
      .addr(cmd.load ? addr : waddr_ff), .wr_data(wr_data), .rd_data(rd_data));

   // restoring divider, one quotient bit per cycle
   logic [SUM_WIDTH*3-1:0] num_ff;
   logic [SUM_WIDTH*3-1:0] quo_ff;
   logic [SUM_WIDTH-1:0]   rem_ff [3];
   logic [AREA_W-1:0]      area_ff;
   logic [4:0]             cnt_ff;
   logic                   div_busy_ff, fl_ff;
   logic [SUM_WIDTH:0]     trial [3];
   always_comb begin
      for (int k = 0; k < 3; k++)
         trial[k] = {rem_ff[k], num_ff[SUM_WIDTH*(k+1)-1]} - (SUM_WIDTH+1)'(area_ff);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0; rsp_valid <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         if (err_word) begin
            rsp_valid <= 1'b1;
            rsp_data <= {24'd0, 1'b1, 1'b1};
         end
         if (cmd.div_start) begin
            div_busy_ff <= 1'b1; cnt_ff <= '0;
            num_ff <= wr_data; fl_ff <= frame_last_ff;
            area_ff <= AREA_W'(block_factor) * AREA_W'(block_factor);
            for (int k = 0; k < 3; k++) rem_ff[k] <= '0;
         end else if (div_busy_ff) begin
            for (int k = 0; k < 3; k++) begin
               num_ff[SUM_WIDTH*k +: SUM_WIDTH] <= num_ff[SUM_WIDTH*k +: SUM_WIDTH] << 1;
               if (!trial[k][SUM_WIDTH]) begin
                  rem_ff[k] <= trial[k][SUM_WIDTH-1:0];
                  quo_ff[SUM_WIDTH*k +: SUM_WIDTH] <=
                     {quo_ff[SUM_WIDTH*k +: SUM_WIDTH-1], 1'b1};
               end else begin
                  rem_ff[k] <= {rem_ff[k][SUM_WIDTH-2:0], num_ff[SUM_WIDTH*(k+1)-1]};
                  quo_ff[SUM_WIDTH*k +: SUM_WIDTH] <=
                     {quo_ff[SUM_WIDTH*k +: SUM_WIDTH-1], 1'b0};
               end
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == 5'(SUM_WIDTH)) begin
               div_busy_ff <= 1'b0;
               rsp_valid <= 1'b1;
               rsp_data <= {quo_ff[39:32], quo_ff[23:16], quo_ff[7:0], fl_ff, 1'b0};
            end
         end
      end
   end

   assign status.busy     = div_busy_ff | norm_word;
   assign status.pass     = pass_ff;
   assign status.emit     = pass_ff && last_ff;
   assign status.div_done = div_busy_ff && cnt_ff == 5'(SUM_WIDTH);
   // the result register frees up this cycle when it drains
   assign status.rsp_full = rsp_valid && !rsp_ready;
endmodule

FILE: hdl/box_average_downscale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_average_downscale: box filter image downscaler
// Crops a raster RGB stream centrally and averages factor-by-factor blocks.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | red, green, blue (8 bits each)
//  rsp     | out | red, green, blue, frame_last, size_error
//  csr     | in  | write enable, index, 13-bit data
// A word passes the read and write states of the row store read-modify-write,
// skipping the write when it falls outside the crop or its frame is dropped;
// a word that completes a block then runs through the bit-serial divider.
// Reset is synchronous; the row store needs no clearing.
// A word is taken only while the result register is empty or draining.
module box_average_downscale #(
   parameter int MAX_SOURCE_SIDE = 4096,
   parameter int MAX_DEST_WIDTH  = 1024,
   parameter int MAX_FACTOR      = 16
) (
   input  logic         clock,
   input  logic         reset,
   bad_stream_if.sink   req,
   bad_stream_if.source rsp,
   input  logic         csr_write,
   input  logic [bad_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bad_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import bad_pkg::*;
   logic [12:0] src_width_ff, src_height_ff, dst_height_ff;
   logic [10:0] dst_width_ff;
   logic [4:0]  factor_ff;
   cmd_type    cmd;
   status_type status;
   logic       fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff <= 13'd640; src_height_ff <= 13'd480;
         dst_width_ff <= 11'd640; dst_height_ff <= 13'd480; factor_ff <= 5'd1;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_SRC_WIDTH:    src_width_ff  <= csr_data;
            REG_SRC_HEIGHT:   src_height_ff <= csr_data;
            REG_DST_WIDTH:    dst_width_ff  <= csr_data[10:0];
            REG_DST_HEIGHT:   dst_height_ff <= csr_data;
            REG_BLOCK_FACTOR: factor_ff     <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign fire = req.valid && req.ready;

   bad_ctrl u_ctrl (.clock(clock), .reset(reset), .req_fire(fire),
      .status(status), .cmd(cmd), .req_ready(req.ready));

   bad_datapath #(.MAX_SOURCE_SIDE(MAX_SOURCE_SIDE), .MAX_DEST_WIDTH(MAX_DEST_WIDTH),
      .MAX_FACTOR(MAX_FACTOR)) u_dp (
      .clock(clock), .reset(reset), .src_width(src_width_ff),
      .src_height(src_height_ff), .dst_width(dst_width_ff),
      .dst_height(dst_height_ff), .block_factor(factor_ff), .pixel(req.data),
      .cmd(cmd), .status(status), .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
      .rsp_data(rsp.data));

   a_no_take_full: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready) else $error("word taken while full");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !req.ready) else $error("word taken during divide");
   a_err_flag: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data[0] |-> rsp.data[1]) else $error("error without last");
endmodule
